// ===== rtl/pdcp_pkg.sv =====
// shared types and constants for the pixel delta color predictor
`default_nettype none
package pdcp_pkg;

  // configuration register indexes
  localparam logic REG_COLOR_MODE = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  localparam int unsigned CFG_DATA_W = 13;

  // color layout codes, code 3 behaves as four channels
  localparam logic [1:0] MODE_ONE   = 2'd0;
  localparam logic [1:0] MODE_THREE = 2'd1;
  localparam logic [1:0] MODE_FOUR  = 2'd2;

  localparam logic [12:0] LINE_WIDTH_RST = 13'd1024;

  // four channel bytes, channel 0 in the low byte
  typedef logic [3:0][7:0] pixel_t;

  // row position of a pixel at acceptance
  typedef struct packed {
    logic first_row;
    logic row_start;
    logic row_end;
  } scan_info_t;

endpackage
`default_nettype wire

// ===== rtl/pdcp_line_mem.sv =====
// line store memory with registered read and write-to-read forwarding
`default_nettype none
module pdcp_line_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic            clk_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire pdcp_pkg::pixel_t wdata_i,
  output      pdcp_pkg::pixel_t rdata_o
);

  pdcp_pkg::pixel_t mem [DEPTH];
  pdcp_pkg::pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // same entry written in this cycle: hand the new word straight through
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/pdcp_scan_ctrl.sv =====
// column counter and first-row tracking for the raster scan
`default_nettype none
module pdcp_scan_ctrl #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned AW        = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic                  image_start_i,
  input  wire logic [12:0]           line_width_i,
  output      logic [AW-1:0]         col_o,
  output      pdcp_pkg::scan_info_t  info_o
);

  localparam int unsigned CMPW = (AW + 1 > 13) ? AW + 1 : 13;

  logic [AW-1:0]   col_q, col_d;
  logic            first_q, first_d;
  logic [AW-1:0]   col_eff;
  logic            first_eff;
  logic [AW:0]     col_nxt;
  logic [CMPW-1:0] lw_ext;
  logic [CMPW-1:0] width_eff;
  logic            row_end;

  always_comb begin
    col_eff   = image_start_i ? '0 : col_q;
    first_eff = image_start_i | first_q;
    col_nxt   = {1'b0, col_eff} + {{AW{1'b0}}, 1'b1};
    lw_ext    = CMPW'(line_width_i);
    // zero behaves as one, anything above the store depth as the depth
    priority if (lw_ext == '0) begin
      width_eff = CMPW'(1);
    end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
      width_eff = CMPW'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext;
    end
    row_end = CMPW'(col_nxt) >= width_eff;
    col_d   = row_end ? '0 : col_nxt[AW-1:0];
    first_d = row_end ? 1'b0 : first_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (fire_i) begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  assign col_o            = col_eff;
  assign info_o.first_row = first_eff;
  assign info_o.row_start = (col_eff == '0);
  assign info_o.row_end   = row_end;

endmodule
`default_nettype wire

// ===== rtl/pdcp_resid.sv =====
// vertical and horizontal differencing with green decorrelation
`default_nettype none
module pdcp_resid (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire pdcp_pkg::pixel_t raw_i,
  input  wire pdcp_pkg::pixel_t above_i,
  input  wire logic             first_row_i,
  input  wire logic             row_start_i,
  input  wire logic [1:0]       color_mode_i,
  output      pdcp_pkg::pixel_t resid_o
);

  pdcp_pkg::pixel_t prev_q;
  pdcp_pkg::pixel_t vd;
  pdcp_pkg::pixel_t val;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vd[c]  = first_row_i ? raw_i[c] : raw_i[c] - above_i[c];
      val[c] = vd[c] - (row_start_i ? 8'd0 : prev_q[c]);
    end
    unique case (color_mode_i)
      pdcp_pkg::MODE_ONE: begin
        resid_o = {8'd0, 8'd0, 8'd0, val[0]};
      end
      pdcp_pkg::MODE_THREE: begin
        resid_o = {8'd0, val[2] - val[1], val[1], val[0] - val[1]};
      end
      default: begin
        resid_o = {val[3], val[2] - val[1], val[1], val[0] - val[1]};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (adv_i) begin
      prev_q <= vd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pixel_delta_color_predictor.sv =====
// top level of the pixel delta color predictor
// Pixels enter in raster order on the in_* channel, one per transaction,
// with image_start_i marking the first pixel of an image. Each pixel gives
// one residual pixel on the out_* channel, row_end_o set on the last pixel
// of a row. Accepting a pixel reads the line store entry of its column and
// loads the middle stage; when that stage advances, the residual is formed,
// the raw pixel is written back to the same entry and the output register
// is loaded. One pixel per cycle is sustained while the receiver takes
// results: the line store takes one read and one write per cycle, and a
// read of the entry being written gets the new word forwarded.
// When the receiver stalls, the output register holds its result and the
// middle stage holds one more pixel; in_ready_o drops only when both are
// full. Reset empties the pipeline, sets four-channel mode, a width of
// 1024 and the first-row flag. The line store is not cleared: the word read
// on the first row of an image is not used. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write it only while no
// transaction is in flight, which the block itself does not enforce.
`default_nettype none
module pixel_delta_color_predictor #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [pdcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic                            image_start_i,
  input  wire logic [7:0]                      chan0_in_i,
  input  wire logic [7:0]                      chan1_in_i,
  input  wire logic [7:0]                      chan2_in_i,
  input  wire logic [7:0]                      chan3_in_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [7:0]                      resid0_o,
  output      logic [7:0]                      resid1_o,
  output      logic [7:0]                      resid2_o,
  output      logic [7:0]                      resid3_o,
  output      logic                            row_end_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [1:0]  color_mode_q;
  logic [12:0] line_width_q;

  logic                 in_fire;
  logic                 s1_adv;
  logic                 s1_valid_q;
  pdcp_pkg::pixel_t     s1_raw_q;
  logic [AW-1:0]        s1_col_q;
  pdcp_pkg::scan_info_t s1_info_q;

  pdcp_pkg::pixel_t     in_pix;
  logic [AW-1:0]        scan_col;
  pdcp_pkg::scan_info_t scan_info;
  pdcp_pkg::pixel_t     above;
  pdcp_pkg::pixel_t     resid;

  logic             out_valid_q;
  pdcp_pkg::pixel_t out_resid_q;
  logic             out_row_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= pdcp_pkg::MODE_FOUR;
      line_width_q <= pdcp_pkg::LINE_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdcp_pkg::REG_COLOR_MODE: color_mode_q <= cfg_data_i[1:0];
        pdcp_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign in_pix     = {chan3_in_i, chan2_in_i, chan1_in_i, chan0_in_i};
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  pdcp_scan_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .image_start_i (image_start_i),
    .line_width_i  (line_width_q),
    .col_o         (scan_col),
    .info_o        (scan_info)
  );

  pdcp_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (in_fire),
    .raddr_i (scan_col),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_raw_q),
    .rdata_o (above)
  );

  // middle stage: the pixel waiting for its line store word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_raw_q  <= in_pix;
      s1_col_q  <= scan_col;
      s1_info_q <= scan_info;
    end
  end

  pdcp_resid u_resid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (s1_adv),
    .raw_i        (s1_raw_q),
    .above_i      (above),
    .first_row_i  (s1_info_q.first_row),
    .row_start_i  (s1_info_q.row_start),
    .color_mode_i (color_mode_q),
    .resid_o      (resid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_resid_q   <= resid;
      out_row_end_q <= s1_info_q.row_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign resid0_o    = out_resid_q[0];
  assign resid1_o    = out_resid_q[1];
  assign resid2_o    = out_resid_q[2];
  assign resid3_o    = out_resid_q[3];
  assign row_end_o   = out_row_end_q;

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while both stages are full");

  a_fire_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted pixel did not reach the middle stage");

  a_image_start_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && image_start_i |=> s1_info_q.first_row && s1_info_q.row_start)
    else $error("image start did not restart the scan");

  a_adv_gives_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced pixel produced no result");

endmodule
`default_nettype wire
